[hw/rtl/ffsa_pkg.sv]
package ffsa_pkg;

   localparam int MEMORY_UNITS_DEF = 8192;
   localparam int MAX_SEGMENTS_DEF = 64;

   localparam int ADDR_W = 13;
   localparam int LEN_W  = 14;
   localparam int STAT_W = 3;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_FIT    = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_BAD_LEN   = 3'd4;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [LEN_W-1:0]  request_length;
      logic [ADDR_W-1:0] block_start;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] granted_address;
   } rsp_type;

   // One table entry; size is held one bit wider than the start field so
   // the whole memory fits at any MEMORY_UNITS up to 65536.
   typedef struct packed {
      logic [16:0] size;
      logic [15:0] start;
      logic        is_free;
   } seg_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_OPEN,
      S_SPLIT,
      S_READ_NEXT,
      S_READ_PREV,
      S_MERGE,
      S_CLOSE,
      S_DONE
   } state_type;

endpackage

[hw/rtl/ffsa_table.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module ffsa_table #(
   parameter int WIDTH = $bits(ffsa_pkg::seg_type),
   parameter int DEPTH = ffsa_pkg::MAX_SEGMENTS_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/first_fit_segment_allocator.sv]
// First-fit segment allocator with coalescing.
// req_ beat: kind (0 allocate, 1 free), request_length, block_start.
// rsp_ beat: status (ok, no fit, table full, not found, bad length) and
// granted_address (start on a good allocate, 0 on a failed one, and the
// echoed block_start on a free). One rsp_ beat per req_ beat, in order.
// One request is worked at a time by a sequencer that walks the segment
// table RAM one entry per cycle (registered read, one write per cycle).
// A request of zero length goes straight to its result; any other is a
// scan up to the hit entry and, where needed, a shift of the entries above
// it to open a slot on a split, a read and merge of the free neighbors on a
// free, and a shift down to close the merged slots. req_ready is high only
// in the idle state, so the next request is taken at the earliest in the
// cycle after the rsp_ beat leaves.
// The result sits in a register; a rsp_ stall only holds the block in its
// done state with the beat unchanged.
// Reset (synchronous) is followed by an init state that writes entry 0 as a
// free segment covering the whole memory; the data of entries beyond the
// count is never used.
module first_fit_segment_allocator #(
   parameter int MEMORY_UNITS = ffsa_pkg::MEMORY_UNITS_DEF,
   parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ffsa_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ffsa_pkg::rsp_type  rsp_data
);
   import ffsa_pkg::*;

   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int SEG_W = $bits(seg_type);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;     // segments in table
   logic [CNT_W-1:0] idx_ff, idx_in;     // matched entry
   logic [CNT_W-1:0] cur_ff, cur_in;     // scan / shift cursor
   logic      pipe_ff, pipe_in;          // read data in flight during a shift
   seg_type   hit_ff, hit_in;            // matched entry as rewritten
   seg_type   rem_ff, rem_in;            // remainder split off the hit
   seg_type   nxt_ff, nxt_in;            // entry after the hit
   logic      nxt_ok_ff, nxt_ok_in;      // next entry exists and is free
   logic [1:0] gap_ff, gap_in;           // slots removed by the close

   logic [IDX_W-1:0] rd_addr;
   logic [SEG_W-1:0] rd_word;
   seg_type          rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   seg_type          wr_data;

   ffsa_table #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS), .IDX_W(IDX_W)) u_table (
      .clock(clock), .rd_addr(rd_addr), .rd_data(rd_word),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   assign rd_data = seg_type'(rd_word);

   logic [16:0] len17;
   logic        at_end, full, hit, split, free_req, prv_ok;

   assign len17    = 17'(req_ff.request_length);
   assign free_req = (req_ff.kind == KIND_FREE);
   assign at_end   = (cur_ff >= cnt_ff);
   assign full     = (cnt_ff == CNT_W'(MAX_SEGMENTS));
   assign split    = (rd_data.size > len17);
   assign hit      = free_req
      ? (!rd_data.is_free && rd_data.start == 16'(req_ff.block_start))
      : (rd_data.is_free && rd_data.size >= len17);
   // previous entry data arrives in the merge state
   assign prv_ok   = (idx_ff != '0) && rd_data.is_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.request_length == '0) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (at_end) begin
               state_in = S_DONE;
            end else if (hit) begin
               if (split) state_in = full ? S_DONE : S_OPEN;
               else state_in = free_req ? S_READ_NEXT : S_DONE;
            end
         end
         S_OPEN: if (cur_ff <= idx_ff) state_in = S_SPLIT;
         S_SPLIT: state_in = free_req ? S_READ_NEXT : S_DONE;
         S_READ_NEXT: state_in = S_READ_PREV;
         S_READ_PREV: state_in = S_MERGE;
         S_MERGE: state_in = (prv_ok || nxt_ok_ff) ? S_CLOSE : S_DONE;
         S_CLOSE: if (cur_ff >= cnt_ff) state_in = S_DONE;
         S_DONE: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      pipe_in   = pipe_ff;
      hit_in    = hit_ff;
      rem_in    = rem_ff;
      nxt_in    = nxt_ff;
      nxt_ok_in = nxt_ok_ff;
      gap_in    = gap_ff;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = rd_data;
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_DONE);
      case (state_ff)
         S_INIT: begin
            // seed one free segment covering the whole memory
            wr_en           = 1'b1;
            wr_data.size    = 17'(MEMORY_UNITS);
            wr_data.start   = '0;
            wr_data.is_free = 1'b1;
         end
         S_IDLE: begin
            // entry 0 is read here so the scan starts with data in hand
            req_in = req_data;
            cur_in = '0;
            rsp_in.status = (req_data.request_length == '0) ? ST_BAD_LEN : ST_NO_FIT;
            rsp_in.granted_address = (req_data.kind == KIND_FREE)
               ? req_data.block_start : '0;
         end
         S_SCAN: begin
            rd_addr = IDX_W'(cur_ff + CNT_W'(1));
            cur_in  = cur_ff + CNT_W'(1);
            if (at_end) begin
               rsp_in.status = free_req ? ST_NOT_FOUND : ST_NO_FIT;
            end else if (hit) begin
               idx_in = cur_ff;
               if (split && full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.status = ST_OK;
                  if (!free_req) rsp_in.granted_address = rd_data.start[ADDR_W-1:0];
                  // rewrite the head now; the shift never touches it
                  wr_en           = 1'b1;
                  wr_addr         = cur_ff[IDX_W-1:0];
                  wr_data.size    = split ? len17 : rd_data.size;
                  wr_data.is_free = free_req;
                  hit_in          = wr_data;
                  rem_in.start    = rd_data.start + len17[15:0];
                  rem_in.size     = rd_data.size - len17;
                  rem_in.is_free  = !free_req;
                  cur_in          = cnt_ff - CNT_W'(1);
                  pipe_in         = 1'b0;
               end
            end
         end
         S_OPEN: begin
            // move entries up one slot, top first
            if (pipe_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(cur_ff + CNT_W'(2));
               wr_data = rd_data;
            end
            if (cur_ff > idx_ff) begin
               rd_addr = cur_ff[IDX_W-1:0];
               cur_in  = cur_ff - CNT_W'(1);
               pipe_in = 1'b1;
            end else begin
               pipe_in = 1'b0;
            end
         end
         S_SPLIT: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(idx_ff + CNT_W'(1));
            wr_data = rem_ff;
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         S_READ_NEXT: begin
            rd_addr = IDX_W'(idx_ff + CNT_W'(1));
         end
         S_READ_PREV: begin
            nxt_in    = rd_data;
            nxt_ok_in = (idx_ff + CNT_W'(1) < cnt_ff) && rd_data.is_free;
            rd_addr   = IDX_W'(idx_ff - CNT_W'(1));
         end
         S_MERGE: begin
            pipe_in = 1'b0;
            if (prv_ok) begin
               // previous entry absorbs the freed one and maybe the next
               wr_en           = 1'b1;
               wr_addr         = IDX_W'(idx_ff - CNT_W'(1));
               wr_data.size    = rd_data.size + hit_ff.size
                  + (nxt_ok_ff ? nxt_ff.size : '0);
               wr_data.is_free = 1'b1;
               gap_in          = nxt_ok_ff ? 2'd2 : 2'd1;
               cur_in          = idx_ff + (nxt_ok_ff ? CNT_W'(2) : CNT_W'(1));
            end else if (nxt_ok_ff) begin
               wr_en        = 1'b1;
               wr_addr      = idx_ff[IDX_W-1:0];
               wr_data      = hit_ff;
               wr_data.size = hit_ff.size + nxt_ff.size;
               gap_in       = 2'd1;
               cur_in       = idx_ff + CNT_W'(2);
            end
         end
         S_CLOSE: begin
            // move entries down by the gap, bottom first
            if (pipe_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(cur_ff - CNT_W'(1) - CNT_W'(gap_ff));
               wr_data = rd_data;
            end
            if (cur_ff < cnt_ff) begin
               rd_addr = cur_ff[IDX_W-1:0];
               cur_in  = cur_ff + CNT_W'(1);
               pipe_in = 1'b1;
            end else begin
               pipe_in = 1'b0;
               cnt_in  = cnt_ff - CNT_W'(gap_ff);
            end
         end
         S_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= CNT_W'(1);
         pipe_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pipe_ff  <= pipe_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      idx_ff    <= idx_in;
      cur_ff    <= cur_in;
      hit_ff    <= hit_in;
      rem_ff    <= rem_in;
      nxt_ff    <= nxt_in;
      nxt_ok_ff <= nxt_ok_in;
      gap_ff    <= gap_in;
   end

   assign rsp_data = rsp_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 && cnt_ff <= CNT_W'(MAX_SEGMENTS)) else $error("count out of range");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result lost under stall");

endmodule
